// ----- design/gblur3_pkg.sv -----
// ----------------------------------------------------------------------------
// gblur3_pkg
// Shared types and constants of the 3x3 RGB Gaussian blur.
// ----------------------------------------------------------------------------
package gblur3_pkg;

  localparam int unsigned PIX_W          = 8;
  localparam int unsigned CHAN_N         = 3;
  localparam int unsigned RGB_W          = PIX_W * CHAN_N;
  localparam int unsigned FW_W           = 11;
  localparam int unsigned FH_W           = 12;
  localparam int unsigned CFG_DATA_W     = 12;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned NORM_SHIFT     = 4;
  localparam int unsigned SUM_W          = PIX_W + NORM_SHIFT;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

  // 1-2-1 / 2-4-2 / 1-2-1, indexed [row][col]
  localparam logic [2:0] KERNEL [3][3] = '{
    '{3'd1, 3'd2, 3'd1},
    '{3'd2, 3'd4, 3'd2},
    '{3'd1, 3'd2, 3'd1}
  };

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } item_kind_e;

  // border mask of one window, bit 0 = top/left, bit 2 = bottom/right
  typedef struct packed {
    logic [2:0] row_ok;
    logic [2:0] col_ok;
  } tap_mask_t;

endpackage

// ----- design/gaussian_blur_3x3_rgb_top.sv -----
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb_top
// Streaming 3x3 Gaussian blur (1-2-1/2-4-2/1-2-1, divide by 16) of RGB pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one word per clock, and the block sustains one
// word per cycle as long as the output side takes its results. Each word goes
// through two stages: the first issues a read of the line memory at the current
// column, the second shifts the 3x3 tap window, writes the column back (middle
// row moves to upper row, the new pixel becomes the middle row) and forms the
// three blurred channels into the output register. The word that releases a
// result is registered in stage B, and its result is then registered in the
// output register. A same-column write and read in the same cycle (frame width
// of one) is forwarded around the memory. The filtered value of a pixel leaves
// frame_width+1 words after that pixel entered, so after the last pixel of a
// frame send frame_width+1 drain words (tuser = 1) to flush the bottom row;
// tlast marks the last result of the frame. Taps outside the frame count as
// zero, so the border gets darker. A configuration write restarts the frame;
// write only while the block is idle. After reset and after each
// configuration write the input side holds tready low while the derived frame
// geometry settles. The line memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_rgb_top
  import gblur3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [RGB_W-1:0]      s_axis_tdata,   // in_red, in_green, in_blue
  input  logic                  s_axis_tuser,   // item_kind
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [RGB_W-1:0]      m_axis_tdata,   // out_red, out_green, out_blue
  output logic                  m_axis_tlast    // frame_end
);

  localparam int unsigned AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WUW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = FH_W + 1;
  localparam int unsigned PW  = WUW + FH_W;
  localparam int unsigned MW  = 2 * RGB_W;

  localparam logic [1:0] GEOM_SETTLE = 2'd2;

  // --------------------------------------------------------------------------
  // Configuration registers and derived frame geometry
  // --------------------------------------------------------------------------
  logic [FW_W-1:0] fw_q, fw_d;
  logic [FH_W-1:0] fh_q, fh_d;
  logic [AW-1:0]   wm1_q, wm1_d;     // used width minus one
  logic [FH_W-1:0] hgt_q, hgt_d;     // used height
  logic [PW-1:0]   lastpos_q, lastpos_d;
  logic [1:0]      cfg_wait_q, cfg_wait_d;  // input hold-off while geometry settles
  logic            cfg_acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  always_comb begin
    fw_d       = fw_q;
    fh_d       = fh_q;
    cfg_wait_d = cfg_wait_q;
    if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  fw_d = cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_d = cfg_data_i[FH_W-1:0];
      endcase
    end
    // hold the input until width, height and last position follow the registers
    if (cfg_acc) begin
      cfg_wait_d = GEOM_SETTLE;
    end else if (cfg_wait_q != '0) begin
      cfg_wait_d = cfg_wait_q - 2'd1;
    end
  end

  // clamp width to 1..MAX_WIDTH, take height 0 as 1
  always_comb begin
    if (fw_q == '0) begin
      wm1_d = '0;
    end else if (int'(fw_q) > int'(MAX_WIDTH)) begin
      wm1_d = AW'(MAX_WIDTH - 1);
    end else begin
      wm1_d = AW'(fw_q - FW_W'(1));
    end
    hgt_d     = (fh_q == '0) ? FH_W'(1) : fh_q;
    lastpos_d = (PW'(wm1_q) + PW'(1)) * PW'(hgt_q) - PW'(1);
  end

  // --------------------------------------------------------------------------
  // Stage A: raster counters, read issue
  // --------------------------------------------------------------------------
  logic [AW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic           s_acc;
  logic [RGB_W-1:0] a_pix;
  logic           a_emit, a_last;
  logic [AW-1:0]  a_cc;
  logic [RW-1:0]  a_cr;
  tap_mask_t      a_mask;

  // stage B registers
  logic           b_v_q, b_v_d;
  logic           b_go;
  logic [AW-1:0]  b_addr_q;
  logic [RGB_W-1:0] b_pix_q;
  logic           b_emit_q, b_last_q;
  tap_mask_t      b_mask_q;

  assign s_axis_tready = (~b_v_q | b_go) & (cfg_wait_q == '0);
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  // drain words enter as black pixels; repack to red in the lowest byte
  assign a_pix = (item_kind_e'(s_axis_tuser) == KIND_DRAIN) ? '0 :
                 {s_axis_tdata[PIX_W-1:0], s_axis_tdata[2*PIX_W-1:PIX_W],
                  s_axis_tdata[RGB_W-1:2*PIX_W]};

  always_comb begin
    a_emit = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
    a_cc   = (col_q == '0) ? wm1_q : col_q - AW'(1);
    a_cr   = (col_q == '0) ? row_q - RW'(2) : row_q - RW'(1);
    a_mask.row_ok = {(({1'b0, a_cr} + (RW+1)'(1)) < (RW+1)'(hgt_q)), 1'b1, (a_cr != '0)};
    a_mask.col_ok = {(a_cc != wm1_q), 1'b1, (a_cc != '0)};
    a_last = a_emit && (pos_q >= lastpos_q);

    col_d = col_q;
    row_d = row_q;
    pos_d = pos_q;
    if (cfg_acc) begin
      col_d = '0;
      row_d = '0;
      pos_d = '0;
    end else if (s_acc) begin
      if (a_last) begin
        // restart the frame after its last result
        col_d = '0;
        row_d = '0;
        pos_d = '0;
      end else begin
        if (col_q == wm1_q) begin
          col_d = '0;
          row_d = row_q + RW'(1);
        end else begin
          col_d = col_q + AW'(1);
        end
        if (a_emit) begin
          pos_d = pos_q + PW'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: {middle row, upper row} per column
  // --------------------------------------------------------------------------
  logic [MW-1:0]    line_mem [MAX_WIDTH];
  logic [MW-1:0]    rd_q;
  logic [MW-1:0]    fwd_data_q;
  logic             fwd_q, fwd_d;
  logic [MW-1:0]    eff;
  logic [RGB_W-1:0] b_up, b_mid;
  logic [MW-1:0]    wr_word;

  assign eff     = fwd_q ? fwd_data_q : rd_q;
  assign b_up    = eff[RGB_W-1:0];
  assign b_mid   = eff[MW-1:RGB_W];
  assign wr_word = {b_pix_q, b_mid};
  assign fwd_d   = b_go && (b_addr_q == col_q);

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      rd_q       <= line_mem[col_q];
      fwd_data_q <= wr_word;
    end
    if (b_go) begin
      line_mem[b_addr_q] <= wr_word;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: window shift, filter, output register
  // --------------------------------------------------------------------------
  logic [RGB_W-1:0] win_q [3][3];
  logic [RGB_W-1:0] win_n [3][3];
  logic             out_v_q, out_v_d;
  logic [RGB_W-1:0] out_data_q;
  logic             out_last_q;
  logic [RGB_W-1:0] blur_rgb;

  assign b_go    = b_v_q & (~b_emit_q | ~out_v_q | m_axis_tready);
  assign b_v_d   = s_acc | (b_v_q & ~b_go);
  assign out_v_d = (b_go & b_emit_q) | (out_v_q & ~m_axis_tready);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_n[i][0] = win_q[i][1];
      win_n[i][1] = win_q[i][2];
    end
    win_n[0][2] = b_up;
    win_n[1][2] = b_mid;
    win_n[2][2] = b_pix_q;
  end

  function automatic logic [PIX_W-1:0] blur_chan(
    input logic [RGB_W-1:0] w [3][3],
    input tap_mask_t        m,
    input int unsigned      sh
  );
    logic [SUM_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (m.row_ok[i] && m.col_ok[j]) begin
          sum = sum + SUM_W'((w[i][j] >> sh) & RGB_W'(8'hFF)) * SUM_W'(KERNEL[i][j]);
        end
      end
    end
    return sum[SUM_W-1:NORM_SHIFT];
  endfunction

  // output word: red in the top byte
  assign blur_rgb = {blur_chan(win_n, b_mask_q, 0),
                     blur_chan(win_n, b_mask_q, PIX_W),
                     blur_chan(win_n, b_mask_q, 2 * PIX_W)};

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      b_addr_q <= col_q;
      b_pix_q  <= a_pix;
      b_mask_q <= a_mask;
      b_last_q <= a_last;
    end
    if (b_go && b_emit_q) begin
      out_data_q <= blur_rgb;
      out_last_q <= b_last_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= FRAME_WIDTH_RST;
      fh_q       <= FRAME_HEIGHT_RST;
      wm1_q      <= AW'(DEF_MAX_WIDTH - 1);
      hgt_q      <= FRAME_HEIGHT_RST;
      lastpos_q  <= '0;
      cfg_wait_q <= GEOM_SETTLE;
      col_q      <= '0;
      row_q      <= '0;
      pos_q      <= '0;
      b_v_q      <= 1'b0;
      b_emit_q   <= 1'b0;
      fwd_q      <= 1'b0;
      out_v_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      fw_q       <= fw_d;
      fh_q       <= fh_d;
      wm1_q      <= wm1_d;
      hgt_q      <= hgt_d;
      lastpos_q  <= lastpos_d;
      cfg_wait_q <= cfg_wait_d;
      col_q      <= col_d;
      row_q      <= row_d;
      pos_q      <= pos_d;
      b_v_q      <= b_v_d;
      out_v_q    <= out_v_d;
      if (s_acc) begin
        b_emit_q <= a_emit;
        fwd_q    <= fwd_d;
      end
      // clear the window on a restart, else advance it with the word in B
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (cfg_acc || (b_go && b_last_q)) begin
            win_q[i][j] <= '0;
          end else if (b_go) begin
            win_q[i][j] <= win_n[i][j];
          end
        end
      end
    end
  end

endmodule
